[rtl/rdq_pkg.sv]
// Shared types and constants for the record deque with search.
`default_nettype none

package rdq_pkg;

	localparam int DEPTH   = 16;
	localparam int KEY_W   = 16;
	localparam int LABEL_W = 64;
	localparam int TAG_W   = 8;
	localparam int CAP_W   = 5;
	localparam int POS_W   = 4;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [LABEL_W-1:0] label;
		logic [TAG_W-1:0]   tag;
	} rec_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_TAKE_PREV,
		CELL_TAKE_NEXT
	} cell_op_t;

	typedef enum logic [2:0] {
		CMD_INS_FRONT  = 3'd0,
		CMD_INS_REAR   = 3'd1,
		CMD_DEL_FRONT  = 3'd2,
		CMD_DEL_REAR   = 3'd3,
		CMD_TRAV_FRONT = 3'd4,
		CMD_TRAV_REAR  = 3'd5,
		CMD_SRCH_FRONT = 3'd6,
		CMD_SRCH_REAR  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_DONE     = 3'd0,
		STAT_RECORD   = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FIND,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

[rtl/record_deque_with_search.sv]
// Record deque with key search: a chain of record cells and its command sequencer.
//
// Commands arrive on cmd_valid/cmd_ready with command, key, label and tag; a
// transaction takes place when both are high. Results leave on
// rsp_valid/rsp_ready with status, position, out_key, out_label, out_tag and
// last; last marks the final result of a command. cfg_we writes cfg_wdata
// into the capacity register at once; write it only while the block is idle.
// Inserts load the cell chain in the accept cycle, a front insert also shifts
// it, a front delete shifts it; insert and delete results are ready in the next cycle.
// A search compares every cell key in parallel, registers the match vector
// and picks the first hit in the next cycle, waiting for a free output register.
// A traverse emits one record per cycle from the output register while that
// register is free or being emptied.
// Commands are taken one at a time; the next one is accepted once the
// sequencer is idle and the output register is free or being emptied.
// A stalled receiver holds the output register and the sequencer with it.
// Reset empties the deque and sets the capacity to 16; record contents
// are not cleared.
`default_nettype none

module record_deque_with_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  command,
	input  logic [15:0] key,
	input  logic [63:0] label,
	input  logic [7:0]  tag,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic [3:0]  position,
	output logic [15:0] out_key,
	output logic [63:0] out_label,
	output logic [7:0]  out_tag,
	output logic        last
);
	import rdq_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CAP_W-1:0]   cap_q;
	logic [KEY_W-1:0]   key_q, key_d;
	logic               rear_q, rear_d;
	logic [DEPTH-1:0]   match_q, match_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   rem_q, rem_d;

	logic               rsp_valid_q, rsp_valid_d;
	status_t            rsp_status_q, rsp_status_d;
	logic [POS_W-1:0]   rsp_pos_q, rsp_pos_d;
	rec_t               rsp_rec_q, rsp_rec_d;
	logic               rsp_last_q, rsp_last_d;

	cell_op_t           cell_op [DEPTH];
	rec_t               cell_rec [DEPTH];
	logic [DEPTH-1:0]   cell_match;
	rec_t               new_rec;
	logic [IDX_W-1:0]   rd_idx;
	rec_t               rd_rec;
	logic [IDX_W-1:0]   found_idx;
	logic               found;
	logic               slot_free;
	logic               full;
	logic               accept;
	cmd_t               cmd;

	assign new_rec = '{key: key, label: label, tag: tag};
	assign cmd     = cmd_t'(command);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rec_t prev_rec;
		rec_t next_rec;
		if (i == 0) begin : g_first
			assign prev_rec = new_rec;
		end else begin : g_prev
			assign prev_rec = cell_rec[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_rec = cell_rec[i];
		end else begin : g_next
			assign next_rec = cell_rec[i+1];
		end
		rdq_cell u_cell (
			.clk        (clk),
			.op         (cell_op[i]),
			.new_rec    (new_rec),
			.prev_rec   (prev_rec),
			.next_rec   (next_rec),
			.search_key (key_q),
			.rec        (cell_rec[i]),
			.match      (cell_match[i])
		);
	end

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		if (rear_q) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (match_q[i]) begin
					found     = 1'b1;
					found_idx = IDX_W'(i);
				end
			end
		end else begin
			for (int i = DEPTH - 1; i >= 0; i--) begin
				if (match_q[i]) begin
					found     = 1'b1;
					found_idx = IDX_W'(i);
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_d[i] = cell_match[i] && (CNT_W'(i) < count_q);
		end
	end

	assign rd_idx    = (state_q == ST_FIND) ? found_idx : idx_q;
	assign rd_rec    = cell_rec[rd_idx];
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign full      = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(DEPTH));
	assign cmd_ready = (state_q == ST_IDLE) && slot_free;
	assign accept    = cmd_valid && cmd_ready;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		key_d        = key_q;
		rear_d       = rear_q;
		idx_d        = idx_q;
		rem_d        = rem_q;
		rsp_valid_d  = rsp_valid_q && !rsp_ready;
		rsp_status_d = rsp_status_q;
		rsp_pos_d    = rsp_pos_q;
		rsp_rec_d    = rsp_rec_q;
		rsp_last_d   = rsp_last_q;
		for (int i = 0; i < DEPTH; i++) begin
			cell_op[i] = CELL_HOLD;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rsp_valid_d = 1'b1;
					rsp_pos_d   = '0;
					rsp_rec_d   = '0;
					rsp_last_d  = 1'b1;
					unique case (cmd)
						CMD_INS_FRONT, CMD_INS_REAR: begin
							if (full) begin
								rsp_status_d = STAT_FULL;
							end else begin
								rsp_status_d = STAT_DONE;
								count_d      = count_q + 1'b1;
								for (int i = 0; i < DEPTH; i++) begin
									if (cmd == CMD_INS_FRONT) begin
										cell_op[i] = (i == 0) ? CELL_LOAD : CELL_TAKE_PREV;
									end else if (CNT_W'(i) == count_q) begin
										cell_op[i] = CELL_LOAD;
									end
								end
							end
						end
						CMD_DEL_FRONT, CMD_DEL_REAR: begin
							if (count_q == '0) begin
								rsp_status_d = STAT_EMPTY;
							end else begin
								rsp_status_d = STAT_DONE;
								count_d      = count_q - 1'b1;
								if (cmd == CMD_DEL_FRONT) begin
									for (int i = 0; i < DEPTH; i++) begin
										cell_op[i] = CELL_TAKE_NEXT;
									end
								end
							end
						end
						CMD_TRAV_FRONT, CMD_TRAV_REAR: begin
							if (count_q == '0) begin
								rsp_status_d = STAT_EMPTY;
							end else begin
								rsp_valid_d = rsp_valid_q && !rsp_ready;
								rear_d      = (cmd == CMD_TRAV_REAR);
								idx_d       = (cmd == CMD_TRAV_REAR) ?
									IDX_W'(count_q - 1'b1) : '0;
								rem_d       = count_q;
								state_d     = ST_EMIT;
							end
						end
						CMD_SRCH_FRONT, CMD_SRCH_REAR: begin
							rsp_valid_d = rsp_valid_q && !rsp_ready;
							key_d       = key;
							rear_d      = (cmd == CMD_SRCH_REAR);
							state_d     = ST_SEARCH;
						end
						default: begin
							rsp_status_d = STAT_DONE;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				state_d = ST_FIND;
			end
			ST_FIND: begin
				if (slot_free) begin
					rsp_valid_d = 1'b1;
					rsp_last_d  = 1'b1;
					if (found) begin
						rsp_status_d = STAT_RECORD;
						rsp_pos_d    = POS_W'(found_idx);
						rsp_rec_d    = rd_rec;
					end else begin
						rsp_status_d = STAT_NOTFOUND;
						rsp_pos_d    = '0;
						rsp_rec_d    = '0;
					end
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					rsp_valid_d  = 1'b1;
					rsp_status_d = STAT_RECORD;
					rsp_pos_d    = POS_W'(idx_q);
					rsp_rec_d    = rd_rec;
					rsp_last_d   = (rem_q == CNT_W'(1));
					rem_d        = rem_q - 1'b1;
					idx_d        = rear_q ? (idx_q - 1'b1) : (idx_q + 1'b1);
					if (rem_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_W'(16);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q        <= key_d;
		rear_q       <= rear_d;
		match_q      <= match_d;
		idx_q        <= idx_d;
		rem_q        <= rem_d;
		rsp_status_q <= rsp_status_d;
		rsp_pos_q    <= rsp_pos_d;
		rsp_rec_q    <= rsp_rec_d;
		rsp_last_q   <= rsp_last_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_status_q;
	assign position  = rsp_pos_q;
	assign out_key   = rsp_rec_q.key;
	assign out_label = rsp_rec_q.label;
	assign out_tag   = rsp_rec_q.tag;
	assign last      = rsp_last_q;

endmodule

`default_nettype wire

[rtl/rdq_cell.sv]
// One storage cell of the record chain: holds a record and compares its key.
`default_nettype none

module rdq_cell (
	input  logic              clk,
	input  rdq_pkg::cell_op_t op,
	input  rdq_pkg::rec_t     new_rec,
	input  rdq_pkg::rec_t     prev_rec,
	input  rdq_pkg::rec_t     next_rec,
	input  logic [rdq_pkg::KEY_W-1:0] search_key,
	output rdq_pkg::rec_t     rec,
	output logic              match
);
	import rdq_pkg::*;

	rec_t rec_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:      rec_q <= rec_q;
			CELL_LOAD:      rec_q <= new_rec;
			CELL_TAKE_PREV: rec_q <= prev_rec;
			CELL_TAKE_NEXT: rec_q <= next_rec;
			default:        rec_q <= rec_q;
		endcase
	end

	assign rec   = rec_q;
	assign match = (rec_q.key == search_key);

endmodule

`default_nettype wire

[verif/record_deque_checker.sv]
// Checker for the record deque: predicts the results of each command and compares them.
`timescale 1ns / 100ps

module record_deque_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rdq_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                        cmd_valid,
	input  logic                        cmd_ready,
	input  logic [2:0]                  command,
	input  logic [rdq_pkg::KEY_W-1:0]   key,
	input  logic [rdq_pkg::LABEL_W-1:0] label,
	input  logic [rdq_pkg::TAG_W-1:0]   tag,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  logic [2:0]                  status,
	input  logic [rdq_pkg::POS_W-1:0]   position,
	input  logic [rdq_pkg::KEY_W-1:0]   out_key,
	input  logic [rdq_pkg::LABEL_W-1:0] out_label,
	input  logic [rdq_pkg::TAG_W-1:0]   out_tag,
	input  logic                        last,
	output int                          mismatches,
	output int                          outstanding
);
	import rdq_pkg::*;

	typedef struct {
		status_t          st;
		logic [POS_W-1:0] pos;
		rec_t             rec;
		logic             fin;
	} result_t;

	rec_t             held [DEPTH];
	int               held_count;
	logic [CAP_W-1:0] capacity;
	result_t          due_results [$];

	function automatic result_t status_only(status_t s);
		result_t r;
		r.st = s;
		r.pos = '0;
		r.rec = '0;
		r.fin = 1'b1;
		return r;
	endfunction

	function automatic result_t record_at(int idx, logic fin);
		result_t r;
		r.st = STAT_RECORD;
		r.pos = idx[POS_W-1:0];
		r.rec = held[idx];
		r.fin = fin;
		return r;
	endfunction

	task automatic predict_command(cmd_t c, logic [KEY_W-1:0] k, logic [LABEL_W-1:0] l,
		logic [TAG_W-1:0] t);
		int room;
		int i;
		int idx;
		bit found;
		room = (capacity < DEPTH) ? capacity : DEPTH;
		case (c)
		CMD_INS_FRONT, CMD_INS_REAR: begin
			if (held_count >= room) begin
				due_results.push_back(status_only(STAT_FULL));
			end else begin
				if (c == CMD_INS_FRONT) begin
					for (i = held_count; i > 0; i--)
						held[i] = held[i-1];
					idx = 0;
				end else begin
					idx = held_count;
				end
				held[idx] = '{key: k, label: l, tag: t};
				held_count++;
				due_results.push_back(status_only(STAT_DONE));
			end
		end
		CMD_DEL_FRONT, CMD_DEL_REAR: begin
			if (held_count == 0) begin
				due_results.push_back(status_only(STAT_EMPTY));
			end else begin
				if (c == CMD_DEL_FRONT) begin
					for (i = 1; i < held_count; i++)
						held[i-1] = held[i];
				end
				held_count--;
				due_results.push_back(status_only(STAT_DONE));
			end
		end
		CMD_TRAV_FRONT, CMD_TRAV_REAR: begin
			if (held_count == 0) begin
				due_results.push_back(status_only(STAT_EMPTY));
			end else begin
				for (i = 0; i < held_count; i++) begin
					idx = (c == CMD_TRAV_FRONT) ? i : held_count - 1 - i;
					due_results.push_back(record_at(idx, i == held_count - 1));
				end
			end
		end
		default: begin
			found = 1'b0;
			for (i = 0; i < held_count && !found; i++) begin
				idx = (c == CMD_SRCH_FRONT) ? i : held_count - 1 - i;
				if (held[idx].key == k) begin
					due_results.push_back(record_at(idx, 1'b1));
					found = 1'b1;
				end
			end
			if (!found)
				due_results.push_back(status_only(STAT_NOTFOUND));
		end
		endcase
	endtask

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			held_count = 0;
			capacity = DEPTH;
			due_results.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: status expected none, got %0d", $time, status);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					compare_field("status", want.st, status);
					compare_field("position", want.pos, position);
					compare_field("out_key", want.rec.key, out_key);
					compare_field("out_label", want.rec.label, out_label);
					compare_field("out_tag", want.rec.tag, out_tag);
					compare_field("last", want.fin, last);
				end
			end
			if (cfg_we)
				capacity = cfg_wdata;
			if (cmd_valid && cmd_ready)
				predict_command(cmd_t'(command), key, label, tag);
		end
		outstanding = due_results.size();
	end

endmodule

[verif/record_deque_with_search_tb.sv]
// Testbench top for the record deque: drives commands and capacity writes, gives the verdict.
`timescale 1ns / 100ps

module record_deque_with_search_tb;
	import rdq_pkg::*;

	localparam int STALL_LIMIT = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	logic [2:0]  command = CMD_INS_FRONT;
	logic [15:0] key = '0;
	logic [63:0] label = '0;
	logic [7:0]  tag = '0;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [2:0]  status;
	logic [3:0]  position;
	logic [15:0] out_key;
	logic [63:0] out_label;
	logic [7:0]  out_tag;
	logic        last;

	int mismatches;
	int outstanding;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	record_deque_with_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.command   (command),
		.key       (key),
		.label     (label),
		.tag       (tag),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.position  (position),
		.out_key   (out_key),
		.out_label (out_label),
		.out_tag   (out_tag),
		.last      (last)
	);

	record_deque_checker rdq_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.key         (key),
		.label       (label),
		.tag         (tag),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.position    (position),
		.out_key     (out_key),
		.out_label   (out_label),
		.out_tag     (out_tag),
		.last        (last),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Enter and leave at a falling edge.
	task automatic push_cmd(cmd_t c, logic [15:0] k, logic [63:0] l, logic [7:0] t);
		int gap;
		gap = pick_gap(idle_pct);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		key <= k;
		label <= l;
		tag <= t;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_cmd(int ins_pct);
		int r;
		int rest;
		cmd_t c;
		logic [15:0] k;
		logic [63:0] l;
		r = $urandom_range(0, 99);
		rest = (100 - ins_pct) / 3;
		if (r < ins_pct)
			c = $urandom_range(0, 1) ? CMD_INS_REAR : CMD_INS_FRONT;
		else if (r < ins_pct + rest)
			c = $urandom_range(0, 1) ? CMD_DEL_REAR : CMD_DEL_FRONT;
		else if (r < ins_pct + 2 * rest)
			c = $urandom_range(0, 1) ? CMD_TRAV_REAR : CMD_TRAV_FRONT;
		else
			c = $urandom_range(0, 1) ? CMD_SRCH_REAR : CMD_SRCH_FRONT;
		if ($urandom_range(0, 3) == 0)
			k = 16'($urandom);
		else
			k = 16'($urandom_range(0, 7));
		l = {$urandom, $urandom};
		push_cmd(c, k, l, 8'($urandom));
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_capacity(logic [4:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int hold;
		rsp_ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				hold--;
			end else begin
				hold = pick_gap(stall_pct);
				rsp_ready <= (hold == 0);
				if (hold > 0)
					hold--;
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int phase_cap [6];
		int phase_items [6];
		int phase_ins [6];
		int p;
		phase_cap = '{1, 0, 31, 3, 0, 16};
		phase_items = '{8, 5, 22, 14, 17, 25};
		phase_ins = '{50, 60, 75, 40, 50, 55};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_pct = 25;
		stall_pct = 25;
		push_cmd(CMD_DEL_FRONT, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_DEL_REAR, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_TRAV_FRONT, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_TRAV_REAR, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_SRCH_FRONT, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_SRCH_REAR, 16'hffff, 64'h0, 8'h00);
		push_cmd(CMD_INS_FRONT, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_INS_REAR, 16'hffff, 64'hffff_ffff_ffff_ffff, 8'hff);
		push_cmd(CMD_INS_FRONT, 16'h0005, 64'h4142_4344_4546_4748, 8'h5a);
		push_cmd(CMD_INS_REAR, 16'h0005, 64'h7a79_7877_7675_7473, 8'ha5);
		push_cmd(CMD_SRCH_FRONT, 16'h0005, 64'h0, 8'h00);
		push_cmd(CMD_SRCH_REAR, 16'h0005, 64'h0, 8'h00);
		push_cmd(CMD_SRCH_FRONT, 16'h1234, 64'h0, 8'h00);
		push_cmd(CMD_TRAV_FRONT, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_TRAV_REAR, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_DEL_FRONT, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_DEL_REAR, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_TRAV_FRONT, 16'h0000, 64'h0, 8'h00);
		push_cmd(CMD_SRCH_REAR, 16'hffff, 64'h0, 8'h00);

		for (p = 0; p < 6; p++) begin
			drain();
			set_capacity(5'((p == 4) ? $urandom_range(2, 15) : phase_cap[p]));
			idle_pct = (p % 2 == 0) ? 30 : 0;
			stall_pct = (p % 3 == 1) ? 0 : 30;
			repeat (phase_items[p])
				random_cmd(phase_ins[p]);
		end
		drain();
		repeat (10) @(negedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
